### hw/rtl/vt_pkg.sv
package vt_pkg;

  localparam int INW       = 24;
  localparam int OUTW      = 32;
  localparam int PANW      = 16;
  localparam int ANGW      = 16;
  localparam int ZW        = 15;
  localparam int CFGW      = 16;
  localparam int ZOOM_FRAC = 12;
  localparam int ZOOM_MIN  = 205;
  localparam int ZOOM_MAX  = 20890;

  localparam logic [ZW-1:0]   ZOOM_RESET  = 15'd4096;
  localparam logic [PANW-1:0] PAN_X_RESET = 16'd400;
  localparam logic [PANW-1:0] PAN_Y_RESET = 16'd300;
  localparam logic [ANGW-1:0] ANG_RESET   = 16'd0;

  // CORDIC datapath: 30 fraction bits plus sign and headroom
  localparam int CORDIC_W          = 33;
  localparam int CORDIC_FRAC       = 30;
  localparam int CORDIC_MAX_STAGES = 24;
  localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN = 33'sd652032874;

  localparam logic MODE_FWD = 1'b0;
  localparam logic MODE_INV = 1'b1;

  typedef enum logic [1:0] {
    REG_ZOOM  = 2'd0,
    REG_PAN_X = 2'd1,
    REG_PAN_Y = 2'd2,
    REG_ANGLE = 2'd3
  } cfg_reg_t;

  // per-item control that rides along with the datapath
  typedef struct packed {
    logic mode;
    logic neg_x;
    logic neg_y;
  } vt_tag_t;

  // atan(2^-i) with 2^32 = two pi
  function automatic logic [31:0] cordic_atan(input logic [4:0] i);
    logic [31:0] r;
    case (i)
      5'd0:  r = 32'd536870912;
      5'd1:  r = 32'd316933406;
      5'd2:  r = 32'd167458907;
      5'd3:  r = 32'd85004756;
      5'd4:  r = 32'd42667331;
      5'd5:  r = 32'd21354465;
      5'd6:  r = 32'd10679822;
      5'd7:  r = 32'd5340245;
      5'd8:  r = 32'd2670163;
      5'd9:  r = 32'd1335087;
      5'd10: r = 32'd667544;
      5'd11: r = 32'd333772;
      5'd12: r = 32'd166886;
      5'd13: r = 32'd83443;
      5'd14: r = 32'd41722;
      5'd15: r = 32'd20861;
      5'd16: r = 32'd10430;
      5'd17: r = 32'd5215;
      5'd18: r = 32'd2608;
      5'd19: r = 32'd1304;
      5'd20: r = 32'd652;
      5'd21: r = 32'd326;
      5'd22: r = 32'd163;
      5'd23: r = 32'd81;
      default: r = 32'd0;
    endcase
    return r;
  endfunction

endpackage

### hw/rtl/view_transform_2d.sv
// Path: vt_mac stages A to E, then the divider stages, then the output register. The divider works on
//   MW = max(24, 16+COORD_FRAC_BITS) + 16 bits and, for the inverse direction, retires 4 quotient bits a stage.
// Throughput: one item per cycle once cos/sin are ready and while out_ready does not hold the output.
// Sine and cosine come from an iterative CORDIC: after reset and after each rotation_angle
//   write, in_ready stays low while vt_trig loads the angle, runs its CORDIC steps and rounds.
// Reset (synchronous, rst high) empties the pipeline and restores the register defaults.
module view_transform_2d
  import vt_pkg::*;
#(
  parameter int TRIG_FRAC_BITS  = 14,
  parameter int COORD_FRAC_BITS = 8
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [1:0]            cfg_idx,
  input  logic [CFGW-1:0]       cfg_data,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  mode,
  input  logic signed [INW-1:0] in_x,
  input  logic signed [INW-1:0] in_y,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic signed [OUTW-1:0] out_x,
  output logic signed [OUTW-1:0] out_y,
  output logic                  saturated
);

  localparam int PW = PANW + COORD_FRAC_BITS;
  localparam int UW = ((PW > INW) ? PW : INW) + 1;
  localparam int CW = TRIG_FRAC_BITS + 2;
  localparam int MW = UW + ZOOM_FRAC + 3;
  localparam int FW = MW + 2;

  localparam logic signed [FW-1:0] OMAX = {{(FW-OUTW+1){1'b0}}, {(OUTW-1){1'b1}}};
  localparam logic signed [FW-1:0] OMIN = {{(FW-OUTW+1){1'b1}}, {(OUTW-1){1'b0}}};

  logic [ZW-1:0]          zoom;
  logic signed [PANW-1:0] pan_x, pan_y;
  logic [ANGW-1:0]        angle;
  logic [ZW-1:0]          zw;
  logic                   ang_wr;

  logic                   trig_rdy;
  logic signed [CW-1:0]   cos_v, sin_v;

  logic                   mac_in_valid, mac_in_ready, mac_valid, div_ready;
  vt_tag_t                mac_tag;
  logic [MW-1:0]          mac_mx, mac_my;

  logic                   div_valid, out_en;
  vt_tag_t                div_tag;
  logic [MW-1:0]          div_qx, div_qy;

  logic signed [FW-1:0]   sq_x, sq_y, pan_xs, pan_ys, val_x, val_y;
  logic                   sat_x, sat_y;

  // zoom is stored already clamped to its legal range
  assign zw = cfg_data[ZW-1:0];
  assign ang_wr = cfg_we && (cfg_reg_t'(cfg_idx) == REG_ANGLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      zoom  <= ZOOM_RESET;
      pan_x <= PAN_X_RESET;
      pan_y <= PAN_Y_RESET;
      angle <= ANG_RESET;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_idx))
        REG_ZOOM: begin
          if (zw < ZW'(ZOOM_MIN))      zoom <= ZW'(ZOOM_MIN);
          else if (zw > ZW'(ZOOM_MAX)) zoom <= ZW'(ZOOM_MAX);
          else                         zoom <= zw;
        end
        REG_PAN_X: pan_x <= cfg_data[PANW-1:0];
        REG_PAN_Y: pan_y <= cfg_data[PANW-1:0];
        REG_ANGLE: angle <= cfg_data[ANGW-1:0];
        default: ;
      endcase
    end
  end

  vt_trig #(.TRIG_FRAC_BITS(TRIG_FRAC_BITS)) u_trig (
    .clk   (clk),
    .rst   (rst),
    .start (ang_wr),
    .angle (angle),
    .ready (trig_rdy),
    .cos_v (cos_v),
    .sin_v (sin_v)
  );

  assign mac_in_valid = in_valid && trig_rdy;
  assign in_ready     = mac_in_ready && trig_rdy;

  vt_mac #(
    .TRIG_FRAC_BITS  (TRIG_FRAC_BITS),
    .COORD_FRAC_BITS (COORD_FRAC_BITS)
  ) u_mac (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (mac_in_valid),
    .in_ready  (mac_in_ready),
    .mode      (mode),
    .in_x      (in_x),
    .in_y      (in_y),
    .cos_v     (cos_v),
    .sin_v     (sin_v),
    .pan_x     (pan_x),
    .pan_y     (pan_y),
    .zoom      (zoom),
    .out_valid (mac_valid),
    .out_ready (div_ready),
    .out_tag   (mac_tag),
    .out_mag_x (mac_mx),
    .out_mag_y (mac_my)
  );

  vt_div #(.MW(MW), .DB(4)) u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (mac_valid),
    .in_ready  (div_ready),
    .in_tag    (mac_tag),
    .in_mag_x  (mac_mx),
    .in_mag_y  (mac_my),
    .zoom      (zoom),
    .out_valid (div_valid),
    .out_ready (out_en),
    .out_tag   (div_tag),
    .out_q_x   (div_qx),
    .out_q_y   (div_qy)
  );

  // restore sign, add pan for the forward direction, clamp to 32 bits
  assign pan_xs = FW'(pan_x) <<< COORD_FRAC_BITS;
  assign pan_ys = FW'(pan_y) <<< COORD_FRAC_BITS;
  assign sq_x   = div_tag.neg_x ? -FW'(div_qx) : FW'(div_qx);
  assign sq_y   = div_tag.neg_y ? -FW'(div_qy) : FW'(div_qy);
  assign val_x  = (div_tag.mode == MODE_INV) ? sq_x : sq_x + pan_xs;
  assign val_y  = (div_tag.mode == MODE_INV) ? sq_y : sq_y + pan_ys;
  assign sat_x  = (val_x > OMAX) || (val_x < OMIN);
  assign sat_y  = (val_y > OMAX) || (val_y < OMIN);

  assign out_en = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_en) begin
      out_valid <= div_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_en) begin
      out_x     <= (val_x > OMAX) ? OUTW'(OMAX) : (val_x < OMIN) ? OUTW'(OMIN) : OUTW'(val_x);
      out_y     <= (val_y > OMAX) ? OUTW'(OMAX) : (val_y < OMIN) ? OUTW'(OMIN) : OUTW'(val_y);
      saturated <= sat_x || sat_y;
    end
  end

  a_sat_at_limit: assert property (@(posedge clk) disable iff (rst)
    out_valid && saturated |->
      (out_x == OUTW'(OMAX)) || (out_x == OUTW'(OMIN)) ||
      (out_y == OUTW'(OMAX)) || (out_y == OUTW'(OMIN)))
    else $error("saturated flag without a clamped coordinate");

  a_angle_blocks: assert property (@(posedge clk) disable iff (rst)
    ang_wr |=> !in_ready)
    else $error("item accepted while cos/sin are being recomputed");

  a_reset_blocks: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !in_ready)
    else $error("item accepted before cos/sin are available");

endmodule

### hw/rtl/vt_trig.sv
module vt_trig
  import vt_pkg::*;
#(
  parameter int TRIG_FRAC_BITS = 14
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [ANGW-1:0]               angle,
  output logic                          ready,
  output logic signed [TRIG_FRAC_BITS+1:0] cos_v,
  output logic signed [TRIG_FRAC_BITS+1:0] sin_v
);

  localparam int CW  = TRIG_FRAC_BITS + 2;
  localparam int NST = (TRIG_FRAC_BITS + 2 < CORDIC_MAX_STAGES) ?
                       TRIG_FRAC_BITS + 2 : CORDIC_MAX_STAGES;
  localparam int SH  = CORDIC_FRAC - TRIG_FRAC_BITS;
  localparam int KW  = $clog2(NST);

  typedef enum logic [1:0] {T_IDLE, T_LOAD, T_RUN, T_ROUND} state_t;

  state_t                      state;
  logic [KW-1:0]               cnt;
  logic [1:0]                  quad;
  logic signed [CORDIC_W-1:0]  x, y, zr;

  logic [31:0]                 a_full, a_bias, a_res;
  logic signed [CORDIC_W-1:0]  xs, ys, at;
  logic signed [CW-1:0]        c0, s0;

  function automatic logic signed [CW-1:0] round_trig(input logic signed [CORDIC_W-1:0] v);
    logic [CORDIC_W-1:0] mag;
    logic [CORDIC_W-1:0] q;
    mag = v[CORDIC_W-1] ? CORDIC_W'(-v) : CORDIC_W'(v);
    q   = (mag + (CORDIC_W'(1) << (SH - 1))) >> SH;
    return v[CORDIC_W-1] ? -CW'(q) : CW'(q);
  endfunction

  // nearest quadrant, residue within +-45 degrees
  assign a_full = {angle, 16'd0};
  assign a_bias = a_full + 32'h2000_0000;
  assign a_res  = a_full - {a_bias[31:30], 30'd0};

  assign xs = x >>> cnt;
  assign ys = y >>> cnt;
  assign at = CORDIC_W'(cordic_atan(5'(cnt)));
  assign c0 = round_trig(x);
  assign s0 = round_trig(y);

  assign ready = (state == T_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= T_LOAD;
      cnt   <= '0;
    end else if (start) begin
      state <= T_LOAD;
    end else begin
      case (state)
        T_LOAD: begin
          x     <= CORDIC_GAIN;
          y     <= '0;
          zr    <= CORDIC_W'(signed'(a_res));
          quad  <= a_bias[31:30];
          cnt   <= '0;
          state <= T_RUN;
        end
        T_RUN: begin
          if (!zr[CORDIC_W-1]) begin
            x  <= x - ys;
            y  <= y + xs;
            zr <= zr - at;
          end else begin
            x  <= x + ys;
            y  <= y - xs;
            zr <= zr + at;
          end
          cnt <= cnt + 1'b1;
          if (cnt == KW'(NST - 1)) state <= T_ROUND;
        end
        T_ROUND: begin
          case (quad)
            2'd0: begin cos_v <= c0;  sin_v <= s0;  end
            2'd1: begin cos_v <= -s0; sin_v <= c0;  end
            2'd2: begin cos_v <= -c0; sin_v <= -s0; end
            default: begin cos_v <= s0; sin_v <= -c0; end
          endcase
          state <= T_IDLE;
        end
        default: state <= T_IDLE;
      endcase
    end
  end

endmodule

### hw/rtl/vt_mac.sv
module vt_mac
  import vt_pkg::*;
#(
  parameter int TRIG_FRAC_BITS  = 14,
  parameter int COORD_FRAC_BITS = 8
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic                               mode,
  input  logic signed [INW-1:0]              in_x,
  input  logic signed [INW-1:0]              in_y,
  input  logic signed [TRIG_FRAC_BITS+1:0]   cos_v,
  input  logic signed [TRIG_FRAC_BITS+1:0]   sin_v,
  input  logic signed [PANW-1:0]             pan_x,
  input  logic signed [PANW-1:0]             pan_y,
  input  logic [ZW-1:0]                      zoom,
  output logic                               out_valid,
  input  logic                               out_ready,
  output vt_tag_t                            out_tag,
  output logic [((PANW + COORD_FRAC_BITS > INW) ? PANW + COORD_FRAC_BITS : INW) + 15:0]
                                             out_mag_x,
  output logic [((PANW + COORD_FRAC_BITS > INW) ? PANW + COORD_FRAC_BITS : INW) + 15:0]
                                             out_mag_y
);

  localparam int PW  = PANW + COORD_FRAC_BITS;
  localparam int UW  = ((PW > INW) ? PW : INW) + 1;
  localparam int CW  = TRIG_FRAC_BITS + 2;
  localparam int PRD = CW + UW;
  localparam int SW  = PRD + 1;
  localparam int MW  = SW + ZOOM_FRAC - TRIG_FRAC_BITS;
  localparam int PRW = SW + ZW;

  logic va, vb, vc, vd, ve;
  logic ena, enb, enc, end_, ene;

  // stage A
  logic                  mode_a;
  logic signed [UW-1:0]  u_a, v_a;
  logic signed [UW-1:0]  x_ext, y_ext, px_ext, py_ext, px_s, py_s;
  // stage B
  logic                  mode_b;
  logic signed [PRD-1:0] cu, sv, su, cv;
  // stage C
  logic                  mode_c;
  logic                  neg_xc, neg_yc;
  logic [SW-1:0]         mag_xc, mag_yc;
  logic signed [SW-1:0]  sum_x, sum_y;
  // stage D
  vt_tag_t               tag_d;
  logic [PRW-1:0]        prod_x, prod_y;
  logic [ZW-1:0]         zsel;
  // stage E
  logic [PRW:0]          addend, rnd_x, rnd_y;
  logic [PRW:0]          sh_x, sh_y;

  assign ene  = !ve || out_ready;
  assign end_ = !vd || ene;
  assign enc  = !vc || end_;
  assign enb  = !vb || enc;
  assign ena  = !va || enb;
  assign in_ready = ena;

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0; vb <= 1'b0; vc <= 1'b0; vd <= 1'b0; ve <= 1'b0;
    end else begin
      if (ena)  va <= in_valid;
      if (enb)  vb <= va;
      if (enc)  vc <= vb;
      if (end_) vd <= vc;
      if (ene)  ve <= vd;
    end
  end

  // A: offset the point by the pan for the inverse direction
  assign x_ext  = UW'(in_x);
  assign y_ext  = UW'(in_y);
  assign px_ext = UW'(pan_x);
  assign py_ext = UW'(pan_y);
  assign px_s   = px_ext <<< COORD_FRAC_BITS;
  assign py_s   = py_ext <<< COORD_FRAC_BITS;

  always_ff @(posedge clk) begin
    if (ena) begin
      mode_a <= mode;
      u_a    <= (mode == MODE_INV) ? x_ext - px_s : x_ext;
      v_a    <= (mode == MODE_INV) ? y_ext - py_s : y_ext;
    end
  end

  // B: the four rotation products
  always_ff @(posedge clk) begin
    if (enb) begin
      mode_b <= mode_a;
      cu     <= cos_v * u_a;
      sv     <= sin_v * v_a;
      su     <= sin_v * u_a;
      cv     <= cos_v * v_a;
    end
  end

  // C: sums, then sign and magnitude for round-half-away
  assign sum_x = SW'(cu) + SW'(sv);
  assign sum_y = SW'(su) - SW'(cv);

  always_ff @(posedge clk) begin
    if (enc) begin
      mode_c <= mode_b;
      neg_xc <= sum_x[SW-1];
      neg_yc <= sum_y[SW-1];
      mag_xc <= sum_x[SW-1] ? SW'(-sum_x) : SW'(sum_x);
      mag_yc <= sum_y[SW-1] ? SW'(-sum_y) : SW'(sum_y);
    end
  end

  // D: times zoom (forward) or times 2^12 (inverse)
  assign zsel = (mode_c == MODE_INV) ? ZW'(1 << ZOOM_FRAC) : zoom;

  always_ff @(posedge clk) begin
    if (end_) begin
      tag_d  <= '{mode: mode_c, neg_x: neg_xc, neg_y: neg_yc};
      prod_x <= PRW'(mag_xc * zsel);
      prod_y <= PRW'(mag_yc * zsel);
    end
  end

  // E: forward rounds off T+12 bits; inverse pre-divides by 2^T with z/2 bias,
  // leaving an integer division by z
  assign addend = (tag_d.mode == MODE_INV) ?
                  ((PRW+1)'(zoom) << (TRIG_FRAC_BITS - 1)) :
                  ((PRW+1)'(1) << (TRIG_FRAC_BITS + ZOOM_FRAC - 1));
  assign rnd_x  = {1'b0, prod_x} + addend;
  assign rnd_y  = {1'b0, prod_y} + addend;
  assign sh_x   = (tag_d.mode == MODE_INV) ? rnd_x >> TRIG_FRAC_BITS :
                                             rnd_x >> (TRIG_FRAC_BITS + ZOOM_FRAC);
  assign sh_y   = (tag_d.mode == MODE_INV) ? rnd_y >> TRIG_FRAC_BITS :
                                             rnd_y >> (TRIG_FRAC_BITS + ZOOM_FRAC);

  always_ff @(posedge clk) begin
    if (ene) begin
      out_tag   <= tag_d;
      out_mag_x <= MW'(sh_x);
      out_mag_y <= MW'(sh_y);
    end
  end

  assign out_valid = ve;

endmodule

### hw/rtl/vt_div.sv
module vt_div
  import vt_pkg::*;
#(
  parameter int MW = 40,
  parameter int DB = 4
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  vt_tag_t        in_tag,
  input  logic [MW-1:0]  in_mag_x,
  input  logic [MW-1:0]  in_mag_y,
  input  logic [ZW-1:0]  zoom,
  output logic           out_valid,
  input  logic           out_ready,
  output vt_tag_t        out_tag,
  output logic [MW-1:0]  out_q_x,
  output logic [MW-1:0]  out_q_y
);

  localparam int NDS = (MW + DB - 1) / DB;
  localparam int RW  = ZW + 1;

  logic          v   [NDS];
  logic          en  [NDS];
  vt_tag_t       tg  [NDS];
  logic [MW-1:0] wx  [NDS];
  logic [MW-1:0] wy  [NDS];
  logic [RW-1:0] rx  [NDS];
  logic [RW-1:0] ry  [NDS];

  // one restoring step: shift in the next numerator bit, quotient bit into w
  function automatic logic [RW+MW-1:0] div_step(input logic [RW-1:0] r,
                                                input logic [MW-1:0] w,
                                                input logic [ZW-1:0] d);
    logic [RW-1:0] rs;
    logic [MW-1:0] ws;
    rs = {r[ZW-1:0], w[MW-1]};
    ws = w << 1;
    if (rs >= {1'b0, d}) begin
      rs    = rs - {1'b0, d};
      ws[0] = 1'b1;
    end
    return {rs, ws};
  endfunction

  genvar k;
  generate
    for (k = 0; k < NDS; k++) begin : g_st
      logic          src_v;
      vt_tag_t       src_t;
      logic [MW-1:0] src_wx, src_wy, nwx, nwy;
      logic [RW-1:0] src_rx, src_ry, nrx, nry;

      if (k == 0) begin : g_first
        assign src_v  = in_valid;
        assign src_t  = in_tag;
        assign src_wx = in_mag_x;
        assign src_wy = in_mag_y;
        assign src_rx = '0;
        assign src_ry = '0;
      end else begin : g_next
        assign src_v  = v[k-1];
        assign src_t  = tg[k-1];
        assign src_wx = wx[k-1];
        assign src_wy = wy[k-1];
        assign src_rx = rx[k-1];
        assign src_ry = ry[k-1];
      end

      if (k == NDS - 1) begin : g_last_en
        assign en[k] = !v[k] || out_ready;
      end else begin : g_mid_en
        assign en[k] = !v[k] || en[k+1];
      end

      always_comb begin
        nwx = src_wx;
        nwy = src_wy;
        nrx = src_rx;
        nry = src_ry;
        for (int b = 0; b < DB; b++) begin
          if (src_t.mode == MODE_INV && (k * DB + b) < MW) begin
            {nrx, nwx} = div_step(nrx, nwx, zoom);
            {nry, nwy} = div_step(nry, nwy, zoom);
          end
        end
      end

      always_ff @(posedge clk) begin
        if (rst) begin
          v[k] <= 1'b0;
        end else if (en[k]) begin
          v[k] <= src_v;
        end
      end

      always_ff @(posedge clk) begin
        if (en[k]) begin
          tg[k] <= src_t;
          wx[k] <= nwx;
          wy[k] <= nwy;
          rx[k] <= nrx;
          ry[k] <= nry;
        end
      end
    end
  endgenerate

  assign in_ready  = en[0];
  assign out_valid = v[NDS-1];
  assign out_tag   = tg[NDS-1];
  assign out_q_x   = wx[NDS-1];
  assign out_q_y   = wy[NDS-1];

endmodule
